FILE: rtl/tpbb_pkg.sv
`default_nettype none
package tpbb_pkg;
	localparam int MAX_WIDTH = 512;
	localparam int MAX_HEIGHT = 512;
	localparam int MAX_RADIUS = 63;
	localparam int FRAME_CELLS = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = $clog2(FRAME_CELLS);
	localparam int XW = $clog2(MAX_WIDTH + 1);
	localparam int YW = $clog2(MAX_HEIGHT + 1);
	localparam int RW = $clog2(MAX_RADIUS + 1);
	localparam int DIMW = (XW > YW) ? XW : YW;
	localparam int CNTW = $clog2(2 * MAX_RADIUS + 2);
	localparam int SUMW = 8 + CNTW;
	localparam int CFG_W = 10;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RAD1 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RAD2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RAD3 = 3'd4;

	typedef struct packed {
		logic mode;
		logic [23:0] pixel_in;
	} in_item_t;

	typedef struct packed {
		logic [23:0] pixel_out;
		logic last_pixel;
		logic not_ready;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_BLUR, ST_READ, ST_RWAIT, ST_OUT
	} top_state_t;

	typedef enum logic [2:0] {
		BL_IDLE, BL_LINE, BL_PRE, BL_RUN, BL_DIV, BL_NEXT
	} blur_state_t;

	typedef struct packed {
		logic start;
		logic [XW-1:0] width;
		logic [YW-1:0] height;
		logic [RW-1:0] r1;
		logic [RW-1:0] r2;
		logic [RW-1:0] r3;
	} blur_ctl_t;
endpackage
`default_nettype wire

FILE: rtl/three_pass_box_blur.sv
`default_nettype none
// Three-pass box blur. Load a frame in raster order with mode 0 (one cycle each);
// the last pixel starts six memory passes, during which no transaction is taken.
// Each pass divides the window sums of every pixel with the bit-serial divider, and
// preloads the window at the start of each line. A read (mode 1) steps through
// ST_READ and ST_RWAIT to ST_OUT, which holds its result until the receiver takes it;
// a read before the frame is done goes straight to ST_OUT.
module three_pass_box_blur import tpbb_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire in_item_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output out_item_t out_data,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_W-1:0] cfg_data
);
	top_state_t state_q, state_d;
	logic [9:0] width_q, height_q;
	logic [5:0] r1_q, r2_q, r3_q;
	logic [ADDR_W:0] load_q, read_q, size;
	logic done_q;
	logic [XW-1:0] w;
	logic [YW-1:0] h;
	logic [RW-1:0] e1, e2, e3;
	blur_ctl_t ctl;
	logic blur_done, acc;
	logic [ADDR_W-1:0] s_ra, s_wa, t_ra, t_wa, s_wa_b, ra;
	logic [23:0] s_rd, t_rd, s_wd, s_wd_b, t_wd;
	logic s_we, s_we_b, t_we, last_q;

	function automatic logic [RW-1:0] effr(input logic [5:0] rv, input logic [DIMW-1:0] m);
		logic [DIMW-1:0] lim;
		logic [DIMW-1:0] x;
		lim = (m - 1'b1) >> 1;
		x = DIMW'(rv);
		if (x > DIMW'(MAX_RADIUS)) x = DIMW'(MAX_RADIUS);
		if (x > lim) x = lim;
		return RW'(x);
	endfunction

	always_comb begin
		w = (width_q == '0) ? XW'(1) : (width_q > 10'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : XW'(width_q);
		h = (height_q == '0) ? YW'(1) : (height_q > 10'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT) : YW'(height_q);
		size = (ADDR_W + 1)'(w) * (ADDR_W + 1)'(h);
		e1 = effr(r1_q, (w < h) ? DIMW'(w) : DIMW'(h));
		e2 = effr(r2_q, (w < h) ? DIMW'(w) : DIMW'(h));
		e3 = effr(r3_q, (w < h) ? DIMW'(w) : DIMW'(h));
		acc = in_valid && !in_stall;
		ctl.width = w;
		ctl.height = h;
		ctl.r1 = e1;
		ctl.r2 = e2;
		ctl.r3 = e3;
		ctl.start = acc && !in_data.mode &&
			((done_q ? (ADDR_W + 1)'(1) : load_q + 1'b1) >= size);
	end

	tpbb_blur u_blur (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .done(blur_done),
		.src_raddr(s_ra), .src_rdata(s_rd), .src_we(s_we_b), .src_waddr(s_wa_b),
		.src_wdata(s_wd_b), .tmp_raddr(t_ra), .tmp_rdata(t_rd), .tmp_we(t_we),
		.tmp_waddr(t_wa), .tmp_wdata(t_wd)
	);

	always_comb begin
		s_we = s_we_b || (acc && !in_data.mode);
		s_wa = (state_q == ST_BLUR) ? s_wa_b : (done_q ? '0 : load_q[ADDR_W-1:0]);
		s_wd = (state_q == ST_BLUR) ? s_wd_b : in_data.pixel_in;
		ra = (state_q == ST_BLUR) ? s_ra :
			((read_q < size) ? read_q[ADDR_W-1:0] : ADDR_W'(size - 1'b1));
	end

	tpbb_ram #(.WIDTH(24), .DEPTH(FRAME_CELLS)) u_src (
		.clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(ra), .rdata(s_rd));
	tpbb_ram #(.WIDTH(24), .DEPTH(FRAME_CELLS)) u_tmp (
		.clk(clk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (ctl.start) state_d = ST_BLUR;
				else if (acc && in_data.mode) state_d = done_q ? ST_READ : ST_OUT;
			ST_BLUR: if (blur_done) state_d = ST_IDLE;
			ST_READ: state_d = ST_RWAIT;
			ST_RWAIT: state_d = ST_OUT;
			ST_OUT: if (!out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != ST_IDLE);
		out_valid = (state_q == ST_OUT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			width_q <= 10'd512;
			height_q <= 10'd512;
			r1_q <= '0;
			r2_q <= '0;
			r3_q <= '0;
			load_q <= '0;
			read_q <= '0;
			done_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_WIDTH: width_q <= cfg_data;
					REG_HEIGHT: height_q <= cfg_data;
					REG_RAD1: r1_q <= cfg_data[5:0];
					REG_RAD2: r2_q <= cfg_data[5:0];
					REG_RAD3: r3_q <= cfg_data[5:0];
					default: ;
				endcase
			end
			if (acc && !in_data.mode) begin
				if (ctl.start) begin
					load_q <= '0;
					read_q <= '0;
					done_q <= 1'b0;
				end else begin
					load_q <= done_q ? (ADDR_W + 1)'(1) : load_q + 1'b1;
					done_q <= 1'b0;
					read_q <= '0;
				end
			end
			if (blur_done) done_q <= 1'b1;
			if (state_q == ST_READ) begin
				last_q <= (read_q + 1'b1 >= size);
				if (read_q + 1'b1 >= size) begin
					read_q <= '0;
					done_q <= 1'b0;
				end else read_q <= read_q + 1'b1;
			end else if (state_q == ST_IDLE) last_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RWAIT) begin
			out_data.pixel_out <= s_rd;
			out_data.last_pixel <= last_q;
			out_data.not_ready <= 1'b0;
		end else if (state_q == ST_IDLE) begin
			out_data.pixel_out <= '0;
			out_data.last_pixel <= 1'b0;
			out_data.not_ready <= 1'b1;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> in_stall)
		else $error("accepted input while result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(out_data))
		else $error("result changed while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BLUR) |-> !out_valid)
		else $error("result during blur");
endmodule
`default_nettype wire

FILE: rtl/tpbb_ram.sv
`default_nettype none
module tpbb_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: rtl/tpbb_div.sv
`default_nettype none
module tpbb_div import tpbb_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [SUMW-1:0] num,
	input wire logic [CNTW-1:0] den,
	output logic busy,
	output logic [7:0] quo
);
	// restoring divide, one quotient bit per cycle
	logic [SUMW-1:0] rem_q;
	logic [SUMW-1:0] num_q;
	logic [CNTW-1:0] den_q;
	logic [3:0] cnt_q;
	logic [SUMW:0] trial;

	always_comb trial = {rem_q, num_q[SUMW-1]} - {{(SUMW + 1 - CNTW){1'b0}}, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy <= 1'b1;
			cnt_q <= 4'(SUMW);
		end else if (busy) begin
			cnt_q <= cnt_q - 4'd1;
			if (cnt_q == 4'd1) busy <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= num;
			den_q <= den;
		end else if (busy) begin
			num_q <= {num_q[SUMW-2:0], ~trial[SUMW]};
			rem_q <= trial[SUMW] ? {rem_q[SUMW-2:0], num_q[SUMW-1]} : trial[SUMW-1:0];
		end
	end
	assign quo = num_q[7:0];
endmodule
`default_nettype wire

FILE: rtl/tpbb_blur.sv
`default_nettype none
module tpbb_blur import tpbb_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire blur_ctl_t ctl,
	output logic done,
	output logic [ADDR_W-1:0] src_raddr,
	input wire logic [23:0] src_rdata,
	output logic src_we,
	output logic [ADDR_W-1:0] src_waddr,
	output logic [23:0] src_wdata,
	output logic [ADDR_W-1:0] tmp_raddr,
	input wire logic [23:0] tmp_rdata,
	output logic tmp_we,
	output logic [ADDR_W-1:0] tmp_waddr,
	output logic [23:0] tmp_wdata
);
	// per output: read add pixel, read sub pixel, divide three channels
	blur_state_t state_q, state_d;
	logic [2:0] pass_q;
	logic vert_q;
	logic [DIMW-1:0] line_q, j_q, n, nlines;
	logic [DIMW-1:0] pre_q;
	logic [RW-1:0] r;
	logic [SUMW-1:0] sum_q [3];
	logic [1:0] ph_q;
	logic [1:0] ch_q;
	logic [7:0] res_q [3];
	logic [ADDR_W-1:0] raddr;
	logic [23:0] rdata;
	logic div_start, div_busy;
	logic [7:0] quo;
	logic [CNTW-1:0] cnt;
	logic [DIMW:0] lo, hi, addj, subj;
	logic add_ok, sub_ok;
	logic [DIMW-1:0] rdpos;

	always_comb begin
		n = vert_q ? DIMW'(ctl.height) : DIMW'(ctl.width);
		nlines = vert_q ? DIMW'(ctl.width) : DIMW'(ctl.height);
		unique case (pass_q)
			3'd0: r = ctl.r1;
			3'd1: r = ctl.r2;
			default: r = ctl.r3;
		endcase
		addj = (DIMW + 1)'(j_q) + (DIMW + 1)'(r);
		subj = (DIMW + 1)'(j_q) - (DIMW + 1)'(r) - 1'b1;
		add_ok = addj < (DIMW + 1)'(n);
		sub_ok = (DIMW + 1)'(j_q) >= (DIMW + 1)'(r) + 1'b1;
		lo = ((DIMW + 1)'(j_q) >= (DIMW + 1)'(r)) ? (DIMW + 1)'(j_q) - (DIMW + 1)'(r) : '0;
		hi = add_ok ? addj : (DIMW + 1)'(n) - 1'b1;
		cnt = CNTW'(hi - lo + 1'b1);
		rdpos = (state_q == BL_PRE) ? pre_q :
			(ph_q == 2'd0) ? addj[DIMW-1:0] : subj[DIMW-1:0];
	end

	function automatic logic [ADDR_W-1:0] pos(input logic v, input logic [DIMW-1:0] ln,
			input logic [DIMW-1:0] k, input logic [XW-1:0] w);
		logic [ADDR_W-1:0] a;
		if (v) a = ADDR_W'(k) * ADDR_W'(w) + ADDR_W'(ln);
		else a = ADDR_W'(ln) * ADDR_W'(w) + ADDR_W'(k);
		return a;
	endfunction

	always_comb raddr = pos(vert_q, line_q, rdpos, ctl.width);
	assign src_raddr = raddr;
	assign tmp_raddr = raddr;
	assign rdata = vert_q ? tmp_rdata : src_rdata;

	tpbb_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(sum_q[ch_q]), .den(cnt), .busy(div_busy), .quo(quo)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BL_IDLE: if (ctl.start) state_d = BL_LINE;
			BL_LINE: state_d = (r == '0) ? BL_RUN : BL_PRE;
			BL_PRE: if (ph_q == 2'd1 && pre_q + 1'b1 == DIMW'(r)) state_d = BL_RUN;
			BL_RUN: if (ph_q == 2'd3) state_d = BL_DIV;
			BL_DIV: if (ch_q == 2'd2 && ph_q == 2'd2 && !div_busy) state_d = BL_NEXT;
			BL_NEXT: if (j_q + 1'b1 == n && line_q + 1'b1 == nlines && vert_q && pass_q == 3'd2)
				state_d = BL_IDLE;
				else state_d = (j_q + 1'b1 == n) ? BL_LINE : BL_RUN;
			default: state_d = BL_IDLE;
		endcase
	end

	always_comb begin
		div_start = (state_q == BL_DIV) && ph_q == 2'd0;
		done = (state_q == BL_NEXT) && (state_d == BL_IDLE);
		src_we = (state_q == BL_NEXT) && vert_q;
		tmp_we = (state_q == BL_NEXT) && !vert_q;
		src_waddr = pos(vert_q, line_q, j_q, ctl.width);
		tmp_waddr = src_waddr;
		src_wdata = {res_q[0], res_q[1], res_q[2]};
		tmp_wdata = src_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BL_IDLE;
			pass_q <= '0;
			vert_q <= 1'b0;
			line_q <= '0;
			j_q <= '0;
			pre_q <= '0;
			ph_q <= '0;
			ch_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				BL_IDLE: if (ctl.start) begin
					pass_q <= '0;
					vert_q <= 1'b0;
					line_q <= '0;
				end
				BL_LINE: begin
					j_q <= '0;
					pre_q <= '0;
					ph_q <= '0;
				end
				BL_PRE: begin
					if (ph_q == 2'd0) ph_q <= 2'd1;
					else begin
						ph_q <= '0;
						pre_q <= pre_q + 1'b1;
					end
				end
				BL_RUN: ph_q <= (ph_q == 2'd3) ? 2'd0 : ph_q + 1'b1;
				BL_DIV: begin
					if (ph_q == 2'd0) ph_q <= 2'd1;
					else if (ph_q == 2'd1) ph_q <= 2'd2;
					else if (!div_busy) begin
						ph_q <= '0;
						ch_q <= (ch_q == 2'd2) ? 2'd0 : ch_q + 1'b1;
					end
				end
				BL_NEXT: begin
					ph_q <= '0;
					if (j_q + 1'b1 == n) begin
						if (line_q + 1'b1 == nlines) begin
							line_q <= '0;
							vert_q <= !vert_q;
							if (vert_q) pass_q <= pass_q + 1'b1;
						end else line_q <= line_q + 1'b1;
					end else j_q <= j_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// window sums; pixels 0..r-1 are preloaded before position zero
	always_ff @(posedge clk) begin
		if (state_q == BL_LINE) begin
			for (int c = 0; c < 3; c++) sum_q[c] <= '0;
		end
		if ((state_q == BL_RUN && ph_q == 2'd1 && add_ok) ||
				(state_q == BL_PRE && ph_q == 2'd1)) begin
			sum_q[0] <= sum_q[0] + SUMW'(rdata[23:16]);
			sum_q[1] <= sum_q[1] + SUMW'(rdata[15:8]);
			sum_q[2] <= sum_q[2] + SUMW'(rdata[7:0]);
		end
		if (state_q == BL_RUN && ph_q == 2'd3 && sub_ok) begin
			sum_q[0] <= sum_q[0] - SUMW'(rdata[23:16]);
			sum_q[1] <= sum_q[1] - SUMW'(rdata[15:8]);
			sum_q[2] <= sum_q[2] - SUMW'(rdata[7:0]);
		end
		if (state_q == BL_DIV && ph_q == 2'd2 && !div_busy) res_q[ch_q] <= quo;
	end
endmodule
`default_nettype wire

FILE: tb/three_pass_box_blur_tb.sv
`default_nettype none
module three_pass_box_blur_tb import tpbb_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 8000000;

	class blur_scoreboard;
		logic [23:0] frame_px [FRAME_CELLS];
		logic [23:0] line_px [FRAME_CELLS];
		int unsigned width_reg, height_reg;
		int unsigned radius_reg [3];
		int unsigned load_pos, read_pos;
		bit done;
		out_item_t expected_q [$];
		int mismatches;

		function new();
			width_reg = 512;
			height_reg = 512;
			foreach (radius_reg[i]) radius_reg[i] = 0;
			load_pos = 0;
			read_pos = 0;
			done = 0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
			case (idx)
				REG_WIDTH: width_reg = v;
				REG_HEIGHT: height_reg = v;
				REG_RAD1: radius_reg[0] = v[RW-1:0];
				REG_RAD2: radius_reg[1] = v[RW-1:0];
				REG_RAD3: radius_reg[2] = v[RW-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned clamp_dim(int unsigned v, int unsigned lim);
			if (v == 0) return 1;
			return (v > lim) ? lim : v;
		endfunction

		function int unsigned frame_size();
			return clamp_dim(width_reg, MAX_WIDTH) * clamp_dim(height_reg, MAX_HEIGHT);
		endfunction

		// vertical lines read the row-blurred copy and write back to the frame
		function void box_line(bit vertical, int unsigned base, int unsigned stride,
				int unsigned n, int unsigned r);
			int unsigned sums [3];
			int unsigned lo, hi, cnt;
			logic [23:0] p, q;
			sums = '{0, 0, 0};
			for (int unsigned j = 0; j < r && j < n; j++) begin
				p = vertical ? line_px[base + j*stride] : frame_px[base + j*stride];
				for (int c = 0; c < 3; c++) sums[c] += p[8*c +: 8];
			end
			for (int unsigned j = 0; j < n; j++) begin
				if (j + r < n) begin
					p = vertical ? line_px[base + (j+r)*stride] : frame_px[base + (j+r)*stride];
					for (int c = 0; c < 3; c++) sums[c] += p[8*c +: 8];
				end
				if (j >= r + 1) begin
					p = vertical ? line_px[base + (j-r-1)*stride]
						: frame_px[base + (j-r-1)*stride];
					for (int c = 0; c < 3; c++) sums[c] -= p[8*c +: 8];
				end
				lo = (j >= r) ? j - r : 0;
				hi = (j + r < n) ? j + r : n - 1;
				cnt = hi - lo + 1;
				for (int c = 0; c < 3; c++) q[8*c +: 8] = 8'(sums[c] / cnt);
				if (vertical) frame_px[base + j*stride] = q;
				else line_px[base + j*stride] = q;
			end
		endfunction

		function void blur_frame();
			int unsigned w, h, lim, r;
			w = clamp_dim(width_reg, MAX_WIDTH);
			h = clamp_dim(height_reg, MAX_HEIGHT);
			lim = ((w < h ? w : h) - 1) / 2;
			for (int k = 0; k < 3; k++) begin
				r = radius_reg[k] > MAX_RADIUS ? MAX_RADIUS : radius_reg[k];
				if (r > lim) r = lim;
				for (int unsigned i = 0; i < h; i++) box_line(0, i*w, 1, w, r);
				for (int unsigned i = 0; i < w; i++) box_line(1, i, w, h, r);
			end
		endfunction

		function void note_input(in_item_t it);
			int unsigned size, idx;
			out_item_t e;
			size = frame_size();
			if (it.mode == 1'b0) begin
				if (done) begin
					done = 0;
					read_pos = 0;
					load_pos = 0;
				end
				if (load_pos < size) frame_px[load_pos] = it.pixel_in;
				load_pos++;
				if (load_pos >= size) begin
					blur_frame();
					done = 1;
					load_pos = 0;
					read_pos = 0;
				end
				return;
			end
			if (!done) begin
				e = '{pixel_out: 24'h0, last_pixel: 1'b0, not_ready: 1'b1};
			end else begin
				idx = (read_pos < size) ? read_pos : size - 1;
				e.pixel_out = frame_px[idx];
				e.last_pixel = (read_pos + 1 >= size);
				e.not_ready = 1'b0;
				if (e.last_pixel) begin
					read_pos = 0;
					done = 0;
				end else begin
					read_pos++;
				end
			end
			expected_q.push_back(e);
		endfunction

		function void check_result(out_item_t got);
			out_item_t e;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected transaction: %h", got);
				return;
			end
			e = expected_q.pop_front();
			if (got.pixel_out !== e.pixel_out || got.last_pixel !== e.last_pixel
					|| got.not_ready !== e.not_ready) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch at %0t: pixel %h/%h last %b/%b not_ready %b/%b",
						$realtime, e.pixel_out, got.pixel_out, e.last_pixel,
						got.last_pixel, e.not_ready, got.not_ready);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	blur_scoreboard sb = new();
	int items_sent = 0;
	bit hold_req = 0;
	int unsigned cycles = 0;

	three_pass_box_blur dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_result(out_data);
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [23:0] pick_pixel();
		case ($urandom_range(0, 7))
			0: return 24'h000000;
			1: return 24'hffffff;
			default: return 24'($urandom);
		endcase
	endfunction

	// receiver side
	initial begin
		int n;
		out_stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 0;
				out_stall <= 1;
				repeat (300) @(posedge clk);
				out_stall <= 0;
			end else begin
				n = pick_gap();
				if (n > 0) begin
					out_stall <= 1;
					repeat (n) @(posedge clk);
					out_stall <= 0;
				end
			end
		end
	end

	task automatic send(logic mode, logic [23:0] pix);
		in_item_t it;
		int n;
		it.mode = mode;
		it.pixel_in = pix;
		in_valid <= 1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		sb.note_input(it);
		items_sent++;
		n = pick_gap();
		if (n > 0) begin
			in_valid <= 0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 0;
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		sb.write_reg(idx, v);
	endtask

	// one frame: optional early reads, load with stray reads, optional partial read and reload, read back, extra reads
	task automatic frame_phase(int w, int h, int r1, int r2, int r3, bit reload, bit hold);
		int unsigned size;
		wait_drained();
		write_cfg(REG_WIDTH, CFG_W'(w));
		write_cfg(REG_HEIGHT, CFG_W'(h));
		write_cfg(REG_RAD1, CFG_W'(r1));
		write_cfg(REG_RAD2, CFG_W'(r2));
		write_cfg(REG_RAD3, CFG_W'(r3));
		size = sb.frame_size();
		repeat ($urandom_range(0, 2)) send(1'b1, pick_pixel());
		for (int unsigned i = 0; i < size; i++) begin
			if ($urandom_range(0, 15) == 0) send(1'b1, pick_pixel());
			send(1'b0, pick_pixel());
		end
		if (reload) begin
			for (int unsigned i = 0; i < size / 2; i++) send(1'b1, pick_pixel());
			for (int unsigned i = 0; i < size; i++) send(1'b0, pick_pixel());
		end
		if (hold) hold_req = 1;
		for (int unsigned i = 0; i < size; i++) send(1'b1, pick_pixel());
		repeat ($urandom_range(0, 2)) send(1'b1, pick_pixel());
	endtask

	initial begin
		in_valid = 0;
		in_data = '0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send(1'b1, 24'h000000);
		frame_phase(1, 1, 0, 0, 0, 0, 0);
		frame_phase(0, 0, 63, 63, 63, 0, 0);
		frame_phase(3, 2, 63, 1, 0, 0, 0);
		frame_phase(5, 4, 1, 2, 1, 1, 0);
		frame_phase(7, 7, 3, 63, 2, 0, 1);

		while (items_sent < 650) begin
			if ($urandom_range(0, 7) == 0)
				frame_phase($urandom_range(1, 16), $urandom_range(1, 12),
					$urandom & 63, $urandom & 63, $urandom & 63,
					$urandom_range(0, 3) == 0, 0);
			else
				frame_phase($urandom_range(0, 6), $urandom_range(0, 6),
					$urandom_range(0, 3), $urandom_range(0, 3), $urandom & 63,
					$urandom_range(0, 3) == 0, 0);
		end

		wait_drained();
		repeat (50) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
`default_nettype wire

FILE: filelist.f
rtl/tpbb_pkg.sv
rtl/tpbb_ram.sv
rtl/tpbb_div.sv
rtl/tpbb_blur.sv
rtl/three_pass_box_blur.sv
tb/three_pass_box_blur_tb.sv
